### design/tksel_pkg.sv
// shared types and constants for the top-k score feature selector
// no dependencies
package tksel_pkg;

	localparam int MAX_FEATURES = 64;
	localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CNT_W = $clog2(MAX_FEATURES + 1);

	localparam int SCORE_W = 32;
	localparam int INDEX_W = 6;
	localparam int RULE_W = 2;
	localparam int PARAM_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;

	// keep count arithmetic
	localparam int PROD_W = CNT_W + PARAM_W;
	localparam int CEIL_W = 16;
	localparam int PCT_MUL_W = 29;
	localparam int PCT_Q_W = 10;
	localparam logic [PCT_MUL_W-1:0] PCT_RECIP = PCT_MUL_W'(5243);
	localparam int PCT_SHIFT = 19;
	localparam logic [CEIL_W-1:0] PCT_ROUND = CEIL_W'(99);
	localparam logic [PROD_W:0] Q8_ROUND = (PROD_W+1)'(255);

	localparam logic [CFG_INDEX_W-1:0] REG_SELECTION_RULE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_RULE_VALUE = CFG_INDEX_W'(1);

	localparam logic [RULE_W-1:0] RULE_K_BEST = RULE_W'(0);
	localparam logic [RULE_W-1:0] RULE_PERCENTILE = RULE_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC1,
		ST_CALC2,
		ST_CALC3,
		ST_CALC4,
		ST_MARK,
		ST_SCAN,
		ST_ZERO
	} state_t;

	typedef struct packed {
		logic insert;
		logic load_count;
		logic mark_step;
		logic scan_en;
		logic emit_zero;
		logic clear_set;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic marks_done;
		logic emit_done;
		logic out_free;
	} status_t;

endpackage

### design/tksel_ctrl.sv
// sequencing state machine: load, keep count, marking and emit phases
// depends on tksel_pkg
module tksel_ctrl import tksel_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    feature_valid,
	input  logic    last_feature,
	output logic    feature_stall,
	input  status_t status,
	output cmd_t    cmd,
	output state_t  state
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign state = state_q;
	assign accept = feature_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && last_feature) begin
					state_d = ST_CALC1;
				end
			end
			ST_CALC1: state_d = ST_CALC2;
			ST_CALC2: state_d = ST_CALC3;
			ST_CALC3: state_d = ST_CALC4;
			ST_CALC4: state_d = ST_MARK;
			ST_MARK: begin
				if (status.count_zero) begin
					state_d = ST_ZERO;
				end else if (status.marks_done) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.emit_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ZERO: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		feature_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:  cmd.insert = accept;
			ST_CALC4: cmd.load_count = 1'b1;
			ST_MARK: begin
				cmd.mark_step = !status.count_zero && !status.marks_done;
			end
			ST_SCAN: begin
				cmd.scan_en = !status.emit_done;
				cmd.clear_set = status.emit_done;
			end
			ST_ZERO: begin
				cmd.emit_zero = 1'b1;
				cmd.clear_set = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### design/tksel_dp.sv
// datapath: ranked insertion chain, keep count pipeline, kept map and result register
// depends on tksel_pkg
module tksel_dp import tksel_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [SCORE_W-1:0] score,
	input  logic                      cfg_valid,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic                      result_stall,
	output logic                      result_valid,
	output logic [INDEX_W-1:0]        feature_index,
	output logic                      none_selected,
	output logic                      overflow,
	output logic                      last
);

	// configuration
	logic [RULE_W-1:0]  selection_rule_q;
	logic [PARAM_W-1:0] rule_value_q;

	// ranked chain, highest score in cell 0
	logic signed [SCORE_W-1:0] score_q [MAX_FEATURES];
	logic [IDX_W-1:0]          idx_q [MAX_FEATURES];
	logic [MAX_FEATURES-1:0]   ge;

	logic [CNT_W-1:0] total_q;
	logic             overflow_q;
	logic             full;

	// keep count pipeline
	logic [PROD_W-1:0]    prod_s1;
	logic [CEIL_W-1:0]    ceil_s2;
	logic [CEIL_W-1:0]    ceil_s3;
	logic [PCT_Q_W-1:0]   pct_s3;
	logic [PCT_MUL_W-1:0] pct_mul;
	logic [PROD_W:0]      prod_round;
	logic [CEIL_W-1:0]    raw_count;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     marks_left_q;
	logic [CNT_W-1:0]     emit_left_q;

	// kept map, scanned by shifting towards bit 0
	logic [MAX_FEATURES-1:0] map_q;
	logic [IDX_W-1:0]        ptr_q;
	logic                    out_free;
	logic                    emit_fire;
	logic                    zero_fire;

	logic                    result_valid_q;
	logic [INDEX_W-1:0]      feature_index_q;
	logic                    none_selected_q;
	logic                    overflow_out_q;
	logic                    last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selection_rule_q <= RULE_K_BEST;
			rule_value_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SELECTION_RULE: selection_rule_q <= cfg_data[RULE_W-1:0];
				REG_RULE_VALUE:     rule_value_q <= cfg_data[PARAM_W-1:0];
				default:            ;
			endcase
		end
	end

	assign full = (total_q == CNT_W'(MAX_FEATURES));

	always_comb begin
		for (int i = 0; i < MAX_FEATURES; i++) begin
			ge[i] = (CNT_W'(i) < total_q) && (score_q[i] >= score);
		end
	end

	// equal scores stay ahead of the newcomer, so lower index ranks higher
	always_ff @(posedge clk) begin
		if (cmd.insert && !full) begin
			if (!ge[0]) begin
				score_q[0] <= score;
				idx_q[0] <= total_q[IDX_W-1:0];
			end
			for (int i = 1; i < MAX_FEATURES; i++) begin
				if (!ge[i]) begin
					if (ge[i-1]) begin
						score_q[i] <= score;
						idx_q[i] <= total_q[IDX_W-1:0];
					end else begin
						score_q[i] <= score_q[i-1];
						idx_q[i] <= idx_q[i-1];
					end
				end
			end
		end else if (cmd.mark_step) begin
			for (int i = 0; i < MAX_FEATURES - 1; i++) begin
				idx_q[i] <= idx_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.clear_set) begin
			total_q <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.insert) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				total_q <= total_q + CNT_W'(1);
			end
		end
	end

	// n*p, then ceil(/256), then ceil(/100) by reciprocal for the percentile rule
	assign prod_round = {1'b0, prod_s1} + Q8_ROUND;
	assign pct_mul = PCT_MUL_W'(ceil_s2 + PCT_ROUND) * PCT_RECIP;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(total_q) * PROD_W'(rule_value_q);
		ceil_s2 <= CEIL_W'(prod_round >> 8);
		ceil_s3 <= ceil_s2;
		pct_s3 <= PCT_Q_W'(pct_mul >> PCT_SHIFT);
	end

	always_comb begin
		case (selection_rule_q)
			RULE_K_BEST:     raw_count = CEIL_W'(rule_value_q[PARAM_W-1:8]);
			RULE_PERCENTILE: raw_count = CEIL_W'(pct_s3);
			default:         raw_count = ceil_s3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			marks_left_q <= '0;
			emit_left_q <= '0;
		end else begin
			if (cmd.load_count) begin
				if (raw_count > CEIL_W'(total_q)) begin
					count_q <= total_q;
					marks_left_q <= total_q;
					emit_left_q <= total_q;
				end else begin
					count_q <= raw_count[CNT_W-1:0];
					marks_left_q <= raw_count[CNT_W-1:0];
					emit_left_q <= raw_count[CNT_W-1:0];
				end
			end else begin
				if (cmd.mark_step) begin
					marks_left_q <= marks_left_q - CNT_W'(1);
				end
				if (emit_fire) begin
					emit_left_q <= emit_left_q - CNT_W'(1);
				end
			end
		end
	end

	assign out_free = !result_valid_q || !result_stall;
	assign emit_fire = cmd.scan_en && map_q[0] && out_free;
	assign zero_fire = cmd.emit_zero && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
			ptr_q <= '0;
		end else if (cmd.clear_set) begin
			map_q <= '0;
			ptr_q <= '0;
		end else if (cmd.mark_step) begin
			map_q[idx_q[0]] <= 1'b1;
		end else if (cmd.scan_en && (!map_q[0] || out_free)) begin
			map_q <= map_q >> 1;
			ptr_q <= ptr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_fire || zero_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			feature_index_q <= INDEX_W'(ptr_q);
			none_selected_q <= 1'b0;
			overflow_out_q <= overflow_q;
			last_q <= (emit_left_q == CNT_W'(1));
		end else if (zero_fire) begin
			feature_index_q <= '0;
			none_selected_q <= 1'b1;
			overflow_out_q <= overflow_q;
			last_q <= 1'b1;
		end
	end

	assign status.count_zero = (count_q == '0);
	assign status.marks_done = (marks_left_q == '0);
	assign status.emit_done = (emit_left_q == '0);
	assign status.out_free = out_free;

	assign result_valid = result_valid_q;
	assign feature_index = feature_index_q;
	assign none_selected = none_selected_q;
	assign overflow = overflow_out_q;
	assign last = last_q;

endmodule

### design/top_k_score_feature_selector.sv
// top level of the top-k score feature selector: controller plus datapath
// depends on tksel_pkg, tksel_ctrl, tksel_dp
//
// Scores are taken one per cycle while feature_stall is low; each is placed
// at once into a ranked register chain whose cells all compare against the
// new score in parallel. The score flagged last_feature starts the result
// phase, during which feature_stall stays high: the keep count is formed (a
// multiply, a round-up by 256, a reciprocal multiply for the percentile rule,
// then the clamp), the head of the chain is walked to mark the kept features,
// and the kept map is scanned in index order, while result_stall can hold the
// output register. A set with a zero keep count gives one result with
// none_selected set. Scores beyond MAX_FEATURES are dropped and reported
// through overflow.
module top_k_score_feature_selector import tksel_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      feature_valid,
	output logic                      feature_stall,
	input  logic signed [SCORE_W-1:0] score,
	input  logic                      last_feature,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [INDEX_W-1:0]        feature_index,
	output logic                      none_selected,
	output logic                      overflow,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	cmd_t    cmd;
	status_t status;
	state_t  state;

	assign cfg_ready = 1'b1;

	tksel_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.feature_valid (feature_valid),
		.last_feature  (last_feature),
		.feature_stall (feature_stall),
		.status        (status),
		.cmd           (cmd),
		.state         (state)
	);

	tksel_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.score         (score),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.status        (status),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.feature_index (feature_index),
		.none_selected (none_selected),
		.overflow      (overflow),
		.last          (last)
	);

`ifndef SYNTHESIS
	// the final feature of a set always starts the result phase
	a_last_starts_results: assert property (@(posedge clk) disable iff (!arst_n)
		feature_valid && !feature_stall && last_feature |=> feature_stall)
		else $error("final feature did not stall the input");

	// an empty selection is a single result
	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && none_selected |-> last && (feature_index == '0))
		else $error("none_selected result not marked last");

	// no new transaction is taken while a set is still being emitted
	a_no_input_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> feature_stall && (state == ST_SCAN))
		else $error("input accepted in the middle of an emit");
`endif

endmodule

### tb/tksel_checker.sv
// scoreboard for the top-k score feature selector: watches all three channels,
// keeps its own ranked copy of each score set and checks every selection result
// depends on tksel_pkg
`timescale 1ns / 100ps

module tksel_checker import tksel_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      feature_valid,
	input  logic                      feature_stall,
	input  logic signed [SCORE_W-1:0] score,
	input  logic                      last_feature,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic [INDEX_W-1:0]        feature_index,
	input  logic                      none_selected,
	input  logic                      overflow,
	input  logic                      last,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output int                        mismatches,
	output int                        outstanding
);

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               none;
		logic               ovf;
		logic               fin;
	} selection_t;

	logic signed [SCORE_W-1:0] chain_score [MAX_FEATURES];
	logic [INDEX_W-1:0]        chain_index [MAX_FEATURES];
	int                        stored = 0;
	logic                      dropped = 1'b0;
	logic [RULE_W-1:0]         sel_rule = RULE_K_BEST;
	logic [PARAM_W-1:0]        rule_param = '0;
	selection_t                selection_q [$];
	int                        err_total = 0;

	function automatic int keep_count(input int n);
		int c;
		if (sel_rule == RULE_K_BEST)
			c = rule_param >> 8;
		else if (sel_rule == RULE_PERCENTILE)
			c = (n * rule_param + 25599) / 25600;
		else
			c = (n * rule_param + 255) / 256;
		return (c > n) ? n : c;
	endfunction

	// ranked from highest score down, equal scores keep arrival order
	task automatic rank_score(input logic signed [SCORE_W-1:0] value);
		int pos;
		pos = 0;
		while (pos < stored && chain_score[pos] >= value)
			pos++;
		for (int j = stored; j > pos; j--) begin
			chain_score[j] = chain_score[j-1];
			chain_index[j] = chain_index[j-1];
		end
		chain_score[pos] = value;
		chain_index[pos] = INDEX_W'(stored);
		stored++;
	endtask

	task automatic predict_selection();
		bit         kept [MAX_FEATURES];
		int         count;
		int         emitted;
		selection_t sel;
		count = keep_count(stored);
		emitted = 0;
		foreach (kept[i])
			kept[i] = 1'b0;
		for (int i = 0; i < count; i++)
			kept[chain_index[i]] = 1'b1;
		if (count == 0) begin
			sel.index = '0;
			sel.none = 1'b1;
			sel.ovf = dropped;
			sel.fin = 1'b1;
			selection_q = {selection_q, sel};
		end else begin
			for (int i = 0; i < MAX_FEATURES; i++) begin
				if (kept[i]) begin
					emitted++;
					sel.index = INDEX_W'(i);
					sel.none = 1'b0;
					sel.ovf = dropped;
					sel.fin = (emitted == count);
					selection_q = {selection_q, sel};
				end
			end
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_total++;
		end
	endtask

	task automatic check_selection();
		selection_t sel;
		if (selection_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual index %0d", $time,
				feature_index);
			err_total++;
		end else begin
			sel = selection_q.pop_front();
			compare_field("feature_index", sel.index, feature_index);
			compare_field("none_selected", sel.none, none_selected);
			compare_field("overflow", sel.ovf, overflow);
			compare_field("last", sel.fin, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored = 0;
			dropped = 1'b0;
			sel_rule = RULE_K_BEST;
			rule_param = '0;
			selection_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SELECTION_RULE)
					sel_rule = cfg_data[RULE_W-1:0];
				else if (cfg_index == REG_RULE_VALUE)
					rule_param = cfg_data;
			end
			if (result_valid && !result_stall)
				check_selection();
			if (feature_valid && !feature_stall) begin
				// scores past capacity are dropped but still end the set
				if (stored < MAX_FEATURES)
					rank_score(score);
				else
					dropped = 1'b1;
				if (last_feature) begin
					predict_selection();
					stored = 0;
					dropped = 1'b0;
				end
			end
			outstanding <= selection_q.size();
			mismatches <= err_total;
		end
	end

endmodule

### tb/tb.sv
// testbench top for the top-k score feature selector: clock, reset, stimulus
// and verdict; depends on tksel_pkg, top_k_score_feature_selector, tksel_checker
`timescale 1ns / 100ps

module tb import tksel_pkg::*;;

	localparam logic [RULE_W-1:0] RULE_FRACTION = RULE_W'(2);
	localparam logic [RULE_W-1:0] RULE_UNUSED = RULE_W'(3);
	localparam int ITEMS = 280;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      feature_valid = 1'b0;
	logic                      feature_stall;
	logic signed [SCORE_W-1:0] score = '0;
	logic                      last_feature = 1'b0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic [INDEX_W-1:0]        feature_index;
	logic                      none_selected;
	logic                      overflow;
	logic                      last;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	int                        mismatches;
	int                        outstanding;

	bit burst = 1'b0;
	int items_sent = 0;

	top_k_score_feature_selector dut (.*);

	tksel_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// both registers in one go; valid stays high between the two transactions
	task automatic set_rule(input logic [RULE_W-1:0] code, input logic [PARAM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SELECTION_RULE;
		cfg_data <= CFG_DATA_W'(code);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_RULE_VALUE;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_feature(input logic [SCORE_W-1:0] value, input logic fin);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			feature_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feature_valid <= 1'b1;
		score <= value;
		last_feature <= fin;
		do @(posedge clk); while (feature_stall);
		items_sent++;
	endtask

	task automatic wait_drained();
		feature_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [SCORE_W-1:0] random_score();
		logic [SCORE_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = 32'($urandom_range(0, 7)) - 32'd4;    // dense values, many ties
			1: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic logic [PARAM_W-1:0] random_param(input logic [RULE_W-1:0] code);
		logic [PARAM_W-1:0] p;
		if (code == RULE_K_BEST)
			p = {8'($urandom_range(0, 16)), 8'($urandom())};
		else if (code == RULE_PERCENTILE)
			p = 16'($urandom_range(0, 25600));
		else
			p = 16'($urandom_range(0, 256));
		if ($urandom_range(0, 7) == 0)
			p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return p;
	endfunction

	initial begin : stimulus
		logic [RULE_W-1:0]  code;
		logic [PARAM_W-1:0] p;
		int                 size;
		int                 sets;
		sets = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// top three of the extremes, equal zeros resolved by index
		set_rule(RULE_K_BEST, 16'h0300);
		send_feature(32'h8000_0000, 1'b0);
		send_feature(32'h7FFF_FFFF, 1'b0);
		send_feature(32'h0000_0000, 1'b0);
		send_feature(32'h0000_0000, 1'b0);
		send_feature(32'hFFFF_FFFF, 1'b1);
		wait_drained();
		// fraction below one feature gives nothing selected
		set_rule(RULE_K_BEST, 16'h00FF);
		send_feature(32'd5, 1'b0);
		send_feature(32'd6, 1'b1);
		wait_drained();
		// percentile well over 100 saturates to all features
		set_rule(RULE_PERCENTILE, 16'hFFFF);
		send_feature(-32'sd7, 1'b0);
		send_feature(32'd3, 1'b0);
		send_feature(32'd3, 1'b1);
		wait_drained();
		set_rule(RULE_FRACTION, 16'h0080);
		send_feature(32'd1, 1'b0);
		send_feature(32'd2, 1'b0);
		send_feature(-32'sd2, 1'b1);
		wait_drained();
		// unused rule code behaves as fraction, single-feature set
		set_rule(RULE_UNUSED, 16'h0001);
		send_feature(32'h1234_5678, 1'b1);
		wait_drained();

		while (items_sent < ITEMS) begin
			burst = ($urandom_range(0, 3) == 0);
			code = RULE_W'($urandom_range(0, 3));
			p = random_param(code);
			set_rule(code, p);
			repeat ($urandom_range(1, 3)) begin
				// guarantee one overflowing and one exactly full set early on
				if (sets == 0)
					size = MAX_FEATURES + $urandom_range(1, 6);
				else if (sets == 1 || $urandom_range(0, 29) == 0)
					size = MAX_FEATURES;
				else if ($urandom_range(0, 29) == 0)
					size = MAX_FEATURES + $urandom_range(1, 6);
				else
					size = $urandom_range(1, 12);
				sets++;
				for (int i = 0; i < size; i++)
					send_feature(random_score(), i == size - 1);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : result_side
		int gap;
		forever begin
			gap = burst ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// ends the run once no transaction of any kind has happened for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (feature_valid && !feature_stall) ||
					(result_valid && !result_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
